// ----- rtl/core/lspc_pkg.sv -----
// Package for the layered sprite pixel compositor.
// Holds the display size, the pixel beat type, sprite art, palette and code lookups.
// No dependencies.
package lspc_pkg;

  // Display size
  localparam int DISPLAY_WIDTH  = 80;
  localparam int DISPLAY_HEIGHT = 8;

  // Sprite geometry
  localparam int TILE_W     = 8;
  localparam int TILE_H     = 7;
  localparam int BODY_W     = 10;
  localparam int BODY_H     = 7;
  localparam int HEAD_W     = 9;
  localparam int HEAD_H     = 7;
  localparam int HEAD_SHIFT = 6;

  localparam logic [23:0] BACKGROUND_RGB = 24'h004080;

  // Colour codes used in the sprite art
  localparam logic [7:0] CODE_CLEAR  = " ";
  localparam logic [7:0] CODE_WHITE  = "W";
  localparam logic [7:0] CODE_GRAY   = "G";
  localparam logic [7:0] CODE_DOT    = ".";
  localparam logic [7:0] CODE_RED    = "r";
  localparam logic [7:0] CODE_ORANGE = "o";
  localparam logic [7:0] CODE_YELLOW = "y";
  localparam logic [7:0] CODE_GREEN  = "g";
  localparam logic [7:0] CODE_BLUE   = "b";
  localparam logic [7:0] CODE_PURPLE = "p";
  localparam logic [7:0] CODE_CHEEK  = "s";
  localparam logic [7:0] CODE_PINK   = "P";
  localparam logic [7:0] CODE_SPRINK = "f";

  // One pixel request beat
  typedef struct packed {
    logic [7:0] frame_index;
    logic [6:0] cat_position;
    logic [2:0] pixel_row;
    logic [6:0] pixel_col;
  } pix_t;

  // Sprite art, first character in the top bits, row-major
  localparam logic [8*TILE_W*TILE_H-1:0] TILE_ART = {
    "rrrr    ",
    "oooorrrr",
    "yyyyoooo",
    "ggggyyyy",
    "bbbbgggg",
    "ppppbbbb",
    "    pppp"
  };

  localparam logic [8*BODY_W*BODY_H-1:0] BODY_ART = {
    " BBBBBBBB ",
    "BPPPPfPPPB",
    "BPfPPPPPPB",
    "BPPPfPPfPB",
    "BPPPPPPPPB",
    "BPfPPfPPPB",
    " BBBBBBBB "
  };

  localparam logic [8*HEAD_W*HEAD_H-1:0] HEAD_ART = {
    " BB   BB ",
    " BGBBBGB ",
    "BGWBGWBGB",
    "BGBBGBBGB",
    "BsGGGGGsB",
    " BGGGGGB ",
    "  BBBBB  "
  };

  function automatic logic [7:0] tile_code(input logic [5:0] idx);
    return TILE_ART[8*(TILE_W*TILE_H-1-int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] body_code(input logic [6:0] idx);
    return BODY_ART[8*(BODY_W*BODY_H-1-int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] head_code(input logic [5:0] idx);
    return HEAD_ART[8*(HEAD_W*HEAD_H-1-int'(idx)) +: 8];
  endfunction

  // Map a colour code to 24-bit RGB
  function automatic logic [23:0] palette(input logic [7:0] code);
    logic [23:0] rgb;
    case (code)
      CODE_WHITE:  rgb = 24'hffffff;
      CODE_GRAY:   rgb = 24'h808080;
      CODE_DOT:    rgb = 24'h004080;
      CODE_RED:    rgb = 24'hff0000;
      CODE_ORANGE: rgb = 24'hff8000;
      CODE_YELLOW: rgb = 24'hffff00;
      CODE_GREEN:  rgb = 24'h00ff00;
      CODE_BLUE:   rgb = 24'h0080ff;
      CODE_PURPLE: rgb = 24'h8000ff;
      CODE_CHEEK:  rgb = 24'hff8080;
      CODE_PINK:   rgb = 24'hff80ff;
      CODE_SPRINK: rgb = 24'hff0080;
      default:     rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

// ----- rtl/core/lspc_shade.sv -----
// Combinational layer compositing for one pixel.
// Depends on lspc_pkg for geometry, sprite art and palette.
module lspc_shade (
  input  lspc_pkg::pix_t pix,
  output logic [23:0]    rgb
);

  localparam logic [8:0] DispW = 9'(lspc_pkg::DISPLAY_WIDTH);
  localparam logic [6:0] DispH = 7'(lspc_pkg::DISPLAY_HEIGHT);

  logic [2:0] phase;
  logic [2:0] ph1, ph2, ph3;
  logic       wob1, wob2, wob3;
  logic [7:0] col8, pos8;
  logic [7:0] shifted;
  logic [7:0] tile_start;
  logic [7:0] tile_lim;
  logic       tile_hit;
  logic [2:0] tile_row;
  logic [7:0] tile_ch;
  logic [7:0] body_dx;
  logic [2:0] body_dy;
  logic       body_hit;
  logic [7:0] body_ch;
  logic [7:0] head_x0;
  logic [7:0] head_dx;
  logic [2:0] head_dy;
  logic       head_hit;
  logic [7:0] head_ch;
  logic       off_disp;

  // Frame phase and wobble bits
  assign phase = pix.frame_index[2:0];
  assign ph1   = phase + 3'd1;
  assign ph2   = phase + 3'd2;
  assign ph3   = phase + 3'd3;
  assign wob1  = ph1[2];
  assign wob2  = ph2[2];
  assign wob3  = ph3[2];

  assign col8 = {1'b0, pix.pixel_col};
  assign pos8 = {1'b0, pix.cat_position};

  // Rainbow tile: tile starts left of the position, rows 1 and below
  assign shifted    = col8 + {5'd0, phase};
  assign tile_start = {shifted[7:3], 3'b000};
  assign tile_lim   = pos8 + {5'd0, phase};
  assign tile_row   = pix.pixel_row - 3'd1;
  assign tile_hit   = (tile_start < tile_lim) && (pix.pixel_row != 3'd0);
  assign tile_ch    = tile_hit ? lspc_pkg::tile_code({tile_row, shifted[2:0]})
                               : lspc_pkg::CODE_CLEAR;

  // Body sprite at (pos, wobble 2)
  assign body_dx  = col8 - pos8;
  assign body_dy  = pix.pixel_row - {2'b00, wob2};
  assign body_hit = (col8 >= pos8) && (pix.pixel_row >= {2'b00, wob2}) &&
                    (body_dx < 8'(lspc_pkg::BODY_W)) &&
                    (body_dy < 3'(lspc_pkg::BODY_H));
  assign body_ch  = body_hit
                    ? lspc_pkg::body_code(7'(body_dy) * 7'(lspc_pkg::BODY_W) +
                                          7'(body_dx[3:0]))
                    : lspc_pkg::CODE_CLEAR;

  // Head sprite overlapping the body's right end, wobbling both ways
  assign head_x0  = pos8 + {7'd0, wob3} + 8'(lspc_pkg::HEAD_SHIFT);
  assign head_dx  = col8 - head_x0;
  assign head_dy  = pix.pixel_row - {2'b00, wob1};
  assign head_hit = (col8 >= head_x0) && (pix.pixel_row >= {2'b00, wob1}) &&
                    (head_dx < 8'(lspc_pkg::HEAD_W)) &&
                    (head_dy < 3'(lspc_pkg::HEAD_H));
  assign head_ch  = head_hit
                    ? lspc_pkg::head_code(6'(head_dy) * 6'(lspc_pkg::HEAD_W) +
                                          6'(head_dx[3:0]))
                    : lspc_pkg::CODE_CLEAR;

  assign off_disp = ({2'b00, pix.pixel_col} >= DispW) ||
                    ({4'd0, pix.pixel_row} >= DispH);

  // Back to front, later wins, clear transparent, off-display black
  always_comb begin
    rgb = lspc_pkg::BACKGROUND_RGB;
    if (tile_ch != lspc_pkg::CODE_CLEAR) begin
      rgb = lspc_pkg::palette(tile_ch);
    end
    if (body_ch != lspc_pkg::CODE_CLEAR) begin
      rgb = lspc_pkg::palette(body_ch);
    end
    if (head_ch != lspc_pkg::CODE_CLEAR) begin
      rgb = lspc_pkg::palette(head_ch);
    end
    if (off_disp) begin
      rgb = 24'h000000;
    end
  end

endmodule

// ----- rtl/core/layered_sprite_pixel_compositor.sv -----
// Top level of the layered sprite pixel compositor: beat registers and handshake.
// Depends on lspc_pkg and lspc_shade.
//
// Computes one display pixel per beat from frame, sprite position, row and
// column, with no framebuffer. Throughput is one pixel per clock while
// out_stall is low. The result passes through two register stages (the
// input register, then the layer logic into the result register). Both
// channels use valid/stall; a stalled result holds while one more beat can
// still be taken into the input register. There is no configuration and no
// state beyond the pipeline.
module layered_sprite_pixel_compositor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_frame_index,
  input  logic [6:0] in_cat_position,
  input  logic [2:0] in_pixel_row,
  input  logic [6:0] in_pixel_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  lspc_pkg::pix_t pix_r;
  logic           pix_vld_r, pix_vld_nxt;
  logic [23:0]    rgb_r;
  logic [23:0]    rgb_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic           in_load;
  logic           out_load;

  // Handshake: result stage frees up when empty or taken
  assign out_load = !out_vld_r || !out_stall;
  assign in_stall = pix_vld_r && !out_load;
  assign in_load  = in_valid && !in_stall;

  always_comb begin
    pix_vld_nxt = pix_vld_r;
    if (in_load) begin
      pix_vld_nxt = 1'b1;
    end else if (out_load) begin
      pix_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_load ? pix_vld_r : out_vld_r;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pix_vld_r <= pix_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_load) begin
      pix_r.frame_index  <= in_frame_index;
      pix_r.cat_position <= in_cat_position;
      pix_r.pixel_row    <= in_pixel_row;
      pix_r.pixel_col    <= in_pixel_col;
    end
  end

  lspc_shade u_shade (
    .pix (pix_r),
    .rgb (rgb_nxt)
  );

  // Capture the composited colour
  always_ff @(posedge clk) begin
    if (out_load && pix_vld_r) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_red   = rgb_r[23:16];
  assign out_green = rgb_r[15:8];
  assign out_blue  = rgb_r[7:0];

endmodule
